/* sv/nearest_cluster_assign_top_defines.svh */
// Assertion macros shared by the nearest-cluster assignment block.
`ifndef NEAREST_CLUSTER_ASSIGN_TOP_DEFINES_SVH
`define NEAREST_CLUSTER_ASSIGN_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define NCA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define NCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/nca_pkg.sv */
// Shared constants, codes and types of the nearest-cluster assignment block.
package nca_pkg;

  localparam int STORE_DEPTH_DEF  = 4096;
  localparam int COORD_BITS_DEF   = 18;
  localparam int CLUSTER_BITS_DEF = 8;

  localparam int          KIND_W       = 2;
  localparam int          RADIUS_W     = 32;
  localparam logic [31:0] RADIUS_RESET = 32'd2304;

  // Item kinds carried on tuser
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } nca_state_t;

endpackage

/* sv/nca_dist_pipe.sv */
// Three-stage squared-distance pipeline: absolute differences, squares, sum.
module nca_dist_pipe import nca_pkg::*; #(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CLUSTER_BITS = CLUSTER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [COORD_BITS-1:0]  px,
  input  logic signed [COORD_BITS-1:0]  py,
  input  logic signed [COORD_BITS-1:0]  pz,
  input  logic        [CLUSTER_BITS-1:0] ptag,
  input  logic signed [COORD_BITS-1:0]  qx,
  input  logic signed [COORD_BITS-1:0]  qy,
  input  logic signed [COORD_BITS-1:0]  qz,
  output logic                          busy,
  output logic                          out_valid,
  output logic [2*COORD_BITS+1:0]       out_dist,
  output logic [CLUSTER_BITS-1:0]       out_tag
);

  localparam int DW = 2 * COORD_BITS + 2;

  logic signed [COORD_BITS+1:0] dx, dy, dz;
  logic [COORD_BITS:0]          ax, ay, az;
  logic [DW-1:0]                sqx, sqy, sqz;
  logic [CLUSTER_BITS-1:0]      tag1, tag2;
  logic                         v1, v2;

  // Sign-extended differences, two guard bits so the magnitude never overflows
  always_comb begin
    dx = {{2{px[COORD_BITS-1]}}, px} - {{2{qx[COORD_BITS-1]}}, qx};
    dy = {{2{py[COORD_BITS-1]}}, py} - {{2{qy[COORD_BITS-1]}}, qy};
    dz = {{2{pz[COORD_BITS-1]}}, pz} - {{2{qz[COORD_BITS-1]}}, qz};
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Stage 1 magnitudes, stage 2 squares, stage 3 sum
  always_ff @(posedge clk) begin
    ax       <= dx[COORD_BITS+1] ? (COORD_BITS+1)'(0) - dx[COORD_BITS:0] : dx[COORD_BITS:0];
    ay       <= dy[COORD_BITS+1] ? (COORD_BITS+1)'(0) - dy[COORD_BITS:0] : dy[COORD_BITS:0];
    az       <= dz[COORD_BITS+1] ? (COORD_BITS+1)'(0) - dz[COORD_BITS:0] : dz[COORD_BITS:0];
    tag1     <= ptag;
    sqx      <= DW'(ax) * DW'(ax);
    sqy      <= DW'(ay) * DW'(ay);
    sqz      <= DW'(az) * DW'(az);
    tag2     <= tag1;
    out_dist <= sqx + sqy + sqz;
    out_tag  <= tag2;
  end

  assign busy = v1 | v2 | out_valid;

endmodule

/* sv/nearest_cluster_assign_top.sv */
// Top level of the radius-limited nearest-cluster assignment block.
// Load, clear and ignored items are handled in the idle state without leaving it.
// A query scans the point store one entry per cycle through its single read port,
// then drains the distance pipeline; on an empty store it goes straight to finish.
// The result sits in an output register, so the next item is taken while it waits.
// Synchronous reset empties the store by zeroing the fill count; no clearing pass.
module nearest_cluster_assign_top import nca_pkg::*; #(
  parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CLUSTER_BITS = CLUSTER_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // pos_x, pos_y, pos_z, cluster_tag, zero padding
  input  logic [((3*COORD_BITS+CLUSTER_BITS+7)/8)*8-1:0] s_tdata,
  // kind
  input  logic [KIND_W-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // assigned, best_cluster, best_dist_sq, store_empty, overflowed, zero padding
  output logic [((2*COORD_BITS+CLUSTER_BITS+5+7)/8)*8-1:0] m_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [RADIUS_W-1:0] cfg_data
);

  `include "nearest_cluster_assign_top_defines.svh"

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int DIST_W = 2 * COORD_BITS + 2;
  localparam int ENT_W  = 3 * COORD_BITS + CLUSTER_BITS;
  localparam int OUT_TW = ((2 * COORD_BITS + CLUSTER_BITS + 5 + 7) / 8) * 8;
  localparam int CMP_W  = (DIST_W > RADIUS_W) ? DIST_W : RADIUS_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

  nca_state_t state;

  logic [CNT_W-1:0]        point_count;
  logic                    overflow;
  logic [RADIUS_W-1:0]     radius;
  logic [CNT_W-1:0]        scan_addr;
  logic                    rd_valid;
  logic [ENT_W-1:0]        rd_data;
  logic [ENT_W-1:0]        mem [STORE_DEPTH];

  logic signed [COORD_BITS-1:0] in_x, in_y, in_z;
  logic [CLUSTER_BITS-1:0]      in_tag;
  logic signed [COORD_BITS-1:0] qx, qy, qz;
  logic                         q_empty;

  logic [DIST_W-1:0]       best;
  logic [CLUSTER_BITS-1:0] best_tag;
  logic                    best_first;

  logic                    pipe_busy, pipe_valid;
  logic [DIST_W-1:0]       pipe_dist;
  logic [CLUSTER_BITS-1:0] pipe_tag;

  logic in_fire, load_fire, query_fire, finish_fire;
  logic full, scan_last, hit, ovf_after;
  logic mem_we;
  logic [ENT_W-1:0] mem_wdata;

  // Unpack the input item
  assign in_x   = s_tdata[COORD_BITS-1:0];
  assign in_y   = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_z   = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign in_tag = s_tdata[ENT_W-1:3*COORD_BITS];

  assign s_tready    = (state == ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign in_fire     = s_tvalid & s_tready;
  assign load_fire   = in_fire & (s_tuser == KIND_LOAD);
  assign query_fire  = in_fire & (s_tuser == KIND_QUERY);
  assign finish_fire = (state == ST_FINISH) & (~m_tvalid | m_tready);

  assign full      = (point_count == DEPTH_C);
  assign scan_last = (scan_addr == point_count - CNT_W'(1));
  assign hit       = ~q_empty & (CMP_W'(best) < CMP_W'(radius));
  assign ovf_after = overflow | (hit & full);

  // Append a loaded point, or an assigned hit under its nearest cluster
  assign mem_we    = (load_fire | (finish_fire & hit)) & ~full;
  assign mem_wdata = load_fire ? {in_tag, in_z, in_y, in_x} : {best_tag, qz, qy, qx};

  // Point store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[point_count[ADDR_W-1:0]] <= mem_wdata;
    end
    if (state == ST_SCAN) begin
      rd_data <= mem[scan_addr[ADDR_W-1:0]];
    end
  end

  // Control: sequencer, fill count, sticky overflow, radius, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      overflow    <= 1'b0;
      radius      <= RADIUS_RESET;
      rd_valid    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        radius <= cfg_data;
      end
      // Raise the result valid on completion, drop it after the transfer
      if (finish_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      rd_valid <= (state == ST_SCAN);
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (s_tuser)
              KIND_LOAD: begin
                if (full) overflow <= 1'b1;
                else      point_count <= point_count + CNT_W'(1);
              end
              KIND_QUERY: state <= (point_count == '0) ? ST_FINISH : ST_SCAN;
              KIND_CLEAR: point_count <= '0;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_last) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!rd_valid && !pipe_busy) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish_fire) begin
            state <= ST_IDLE;
            if (hit) begin
              if (full) overflow <= 1'b1;
              else      point_count <= point_count + CNT_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the query, step the scan address, track the running minimum
  always_ff @(posedge clk) begin
    if (query_fire) begin
      qx         <= in_x;
      qy         <= in_y;
      qz         <= in_z;
      q_empty    <= (point_count == '0);
      scan_addr  <= '0;
      best       <= '0;
      best_tag   <= '0;
      best_first <= 1'b1;
    end else begin
      if (state == ST_SCAN) begin
        scan_addr <= scan_addr + CNT_W'(1);
      end
      // strict less keeps the earliest entry on a tie
      if (pipe_valid && (best_first || pipe_dist < best)) begin
        best       <= pipe_dist;
        best_tag   <= pipe_tag;
        best_first <= 1'b0;
      end
    end
    if (finish_fire) begin
      m_tdata <= OUT_TW'({ovf_after, q_empty, best,
                          hit ? best_tag : CLUSTER_BITS'(0), hit});
    end
  end

  nca_dist_pipe #(
    .COORD_BITS   (COORD_BITS),
    .CLUSTER_BITS (CLUSTER_BITS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .px        (rd_data[COORD_BITS-1:0]),
    .py        (rd_data[2*COORD_BITS-1:COORD_BITS]),
    .pz        (rd_data[3*COORD_BITS-1:2*COORD_BITS]),
    .ptag      (rd_data[ENT_W-1:3*COORD_BITS]),
    .qx        (qx),
    .qy        (qy),
    .qz        (qz),
    .busy      (pipe_busy),
    .out_valid (pipe_valid),
    .out_dist  (pipe_dist),
    .out_tag   (pipe_tag)
  );

  // Assertions
  `NCA_ASSERT_SAME(a_count_bound, 1'b1, point_count <= DEPTH_C,
                   "point count exceeds store depth")
  `NCA_ASSERT_SAME(a_no_write_in_scan, (state == ST_SCAN) || rd_valid || pipe_busy,
                   !mem_we, "store written while a scan is in flight")
  `NCA_ASSERT_NEXT(a_full_load_flags, load_fire && full, overflow,
                   "load into full store did not set overflow")

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the nearest-cluster assignment block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nca_pkg::*;

  localparam int CRD_W  = COORD_BITS_DEF;
  localparam int TAG_W  = CLUSTER_BITS_DEF;
  localparam int DIST_W = 2 * CRD_W + 2;
  localparam int DEPTH  = STORE_DEPTH_DEF;
  localparam int SD_W   = ((3 * CRD_W + TAG_W + 7) / 8) * 8;
  localparam int MD_W   = ((2 * CRD_W + TAG_W + 5 + 7) / 8) * 8;
  localparam int N_CTR  = 6;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_SLACK = 16;
  localparam int HOLD_CYCLES = 400;

  // The fourth kind code is unused and must be ignored by the block
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
    logic [TAG_W-1:0]        tag;
  } hit_item_t;

  typedef struct packed {
    bit              assigned;
    bit [TAG_W-1:0]  cluster;
    bit [DIST_W-1:0] dist_sq;
    bit              empty;
    bit              ovf;
  } verdict_t;

  typedef struct {
    hit_item_t hit;
    bit        typed;
    verdict_t  want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [SD_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [MD_W-1:0]  m_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [RADIUS_W-1:0] cfg_data = '0;

  // Predictor state
  logic signed [CRD_W-1:0] pt_x [DEPTH];
  logic signed [CRD_W-1:0] pt_y [DEPTH];
  logic signed [CRD_W-1:0] pt_z [DEPTH];
  logic [TAG_W-1:0]        pt_tag [DEPTH];
  int                      pt_count = 0;
  bit                      ovf_sticky = 1'b0;
  logic [RADIUS_W-1:0]     radius_model = RADIUS_RESET;

  verdict_t pending_verdicts[$];
  dir_row_t dir_rows[$];

  // Cluster centers for random traffic
  int ctr_x [N_CTR];
  int ctr_y [N_CTR];
  int ctr_z [N_CTR];
  logic [TAG_W-1:0] ctr_tag [N_CTR];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int verdicts_checked = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_clears = 0;
  int n_ignored = 0;
  int n_radius = 0;
  int cycle_cnt = 0;
  verdict_t got;
  verdict_t want;

  nearest_cluster_assign_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // pos_x, pos_y, pos_z, cluster_tag, zero padding
    .s_tuser   (s_tuser),   // kind
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // assigned, best_cluster, best_dist_sq, store_empty, overflowed
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint unsigned sq_gap(logic signed [CRD_W-1:0] a,
                                             logic signed [CRD_W-1:0] b);
    longint dd;
    dd = longint'(a) - longint'(b);
    return dd * dd;
  endfunction

  // Append a point, or flag overflow when the store is full
  function automatic void stash_point(logic signed [CRD_W-1:0] x, logic signed [CRD_W-1:0] y,
                                      logic signed [CRD_W-1:0] z, logic [TAG_W-1:0] tag);
    if (pt_count >= DEPTH) begin
      ovf_sticky = 1'b1;
    end else begin
      pt_x[pt_count]   = x;
      pt_y[pt_count]   = y;
      pt_z[pt_count]   = z;
      pt_tag[pt_count] = tag;
      pt_count++;
    end
  endfunction

  // Nearest stored point, radius test and append on assignment
  task automatic predict_hit(input hit_item_t h, output bit has_res, output verdict_t v);
    longint unsigned best;
    longint unsigned d;
    logic [TAG_W-1:0] best_tag;
    bit was_empty;
    has_res = 1'b0;
    v = '0;
    case (h.kind)
      KIND_LOAD: begin
        stash_point(h.x, h.y, h.z, h.tag);
      end
      KIND_CLEAR: begin
        pt_count = 0;
      end
      KIND_QUERY: begin
        was_empty = (pt_count == 0);
        best = 0;
        best_tag = '0;
        for (int i = 0; i < pt_count; i++) begin
          d = sq_gap(pt_x[i], h.x) + sq_gap(pt_y[i], h.y) + sq_gap(pt_z[i], h.z);
          if (i == 0 || d < best) begin
            best = d;
            best_tag = pt_tag[i];
          end
        end
        if (!was_empty && best < {32'd0, radius_model}) begin
          v.assigned = 1'b1;
          v.cluster  = best_tag;
          stash_point(h.x, h.y, h.z, best_tag);
        end
        v.dist_sq = was_empty ? '0 : best[DIST_W-1:0];
        v.empty   = was_empty;
        v.ovf     = ovf_sticky;
        has_res   = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Offer one item after a random gap, then hold it until the transfer
  task automatic send_hit(input hit_item_t h, input bit typed, input verdict_t tv);
    bit has_res;
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= h.kind;
    s_tdata  <= {{(SD_W - 3 * CRD_W - TAG_W){1'b0}}, h.tag, h.z, h.y, h.x};
    do @(posedge clk); while (!s_tready);
    predict_hit(h, has_res, v);
    if (has_res) pending_verdicts = {pending_verdicts, (typed ? tv : v)};
    case (h.kind)
      KIND_LOAD:  n_loads++;
      KIND_QUERY: n_queries++;
      KIND_CLEAR: n_clears++;
      default:    n_ignored++;
    endcase
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Write the radius register while the block is idle
  task automatic write_radius(input logic [RADIUS_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radius_model = val;
    n_radius++;
  endtask

  function automatic void put(logic [KIND_W-1:0] kind, int x, int y, int z, int tag);
    dir_row_t r;
    r.hit = '{kind, CRD_W'(x), CRD_W'(y), CRD_W'(z), TAG_W'(tag)};
    r.typed = 1'b0;
    r.want = '0;
    dir_rows = {dir_rows, r};
  endfunction

  function automatic void put_chk(logic [KIND_W-1:0] kind, int x, int y, int z, int tag,
                                  bit a, int c, longint d, bit e, bit o);
    dir_row_t r;
    r.hit = '{kind, CRD_W'(x), CRD_W'(y), CRD_W'(z), TAG_W'(tag)};
    r.typed = 1'b1;
    r.want = '{a, TAG_W'(c), DIST_W'(d), e, o};
    dir_rows = {dir_rows, r};
  endfunction

  // Mostly points jittered around a cluster center, some anywhere
  function automatic hit_item_t draw_hit();
    hit_item_t h;
    int r;
    int k;
    r = int'($urandom_range(0, 99));
    k = int'($urandom_range(0, N_CTR - 1));
    if (r < 42)      h.kind = KIND_LOAD;
    else if (r < 88) h.kind = KIND_QUERY;
    else if (r < 94) h.kind = KIND_CLEAR;
    else             h.kind = KIND_IGNORED;
    if ($urandom_range(0, 99) < 15) begin
      h.x = CRD_W'($urandom());
      h.y = CRD_W'($urandom());
      h.z = CRD_W'($urandom());
    end else begin
      h.x = CRD_W'(ctr_x[k] + int'($urandom_range(0, 80)) - 40);
      h.y = CRD_W'(ctr_y[k] + int'($urandom_range(0, 80)) - 40);
      h.z = CRD_W'(ctr_z[k] + int'($urandom_range(0, 80)) - 40);
    end
    h.tag = ($urandom_range(0, 99) < 80) ? ctr_tag[k] : TAG_W'($urandom_range(0, 255));
    return h;
  endfunction

  task automatic run_random(input int count);
    hit_item_t h;
    int n;
    n = 0;
    while (n < count) begin
      h = draw_hit();
      send_hit(h, 1'b0, '0);
      if (h.kind != KIND_IGNORED) n++;
    end
  endtask

  // Check each result transfer and pace the ready line
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result with no pending query: %h", m_tdata);
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          got.assigned = m_tdata[0];
          got.cluster  = m_tdata[TAG_W:1];
          got.dist_sq  = m_tdata[TAG_W+DIST_W:TAG_W+1];
          got.empty    = m_tdata[TAG_W+DIST_W+1];
          got.ovf      = m_tdata[TAG_W+DIST_W+2];
          if (want.assigned != got.assigned) begin
            $error("assigned: expected %0d, got %0d", want.assigned, got.assigned);
            mismatches++;
          end
          if (want.cluster != got.cluster) begin
            $error("best_cluster: expected %0d, got %0d", want.cluster, got.cluster);
            mismatches++;
          end
          if (want.dist_sq != got.dist_sq) begin
            $error("best_dist_sq: expected %0d, got %0d", want.dist_sq, got.dist_sq);
            mismatches++;
          end
          if (want.empty != got.empty) begin
            $error("store_empty: expected %0d, got %0d", want.empty, got.empty);
            mismatches++;
          end
          if (want.ovf != got.ovf) begin
            $error("overflowed: expected %0d, got %0d", want.ovf, got.ovf);
            mismatches++;
          end
          verdicts_checked++;
        end
      end
      // Hold off once for a long stretch so queries back up into the input
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    for (int k = 0; k < N_CTR; k++) begin
      ctr_x[k] = int'($urandom_range(0, 262000)) - 131000;
      ctr_y[k] = int'($urandom_range(0, 262000)) - 131000;
      ctr_z[k] = int'($urandom_range(0, 262000)) - 131000;
      ctr_tag[k] = TAG_W'($urandom_range(0, 255));
    end

    // Directed table: empty store, ignored kind, radius edge, extremes, ties
    put_chk(KIND_QUERY,   0,   0,   0,   0, 0, 0, 0, 1, 0);
    put    (KIND_CLEAR,   0,   0,   0,   0);
    put    (KIND_IGNORED, -5, 77,   3, 200);
    put_chk(KIND_QUERY,   1,   2,   3,   0, 0, 0, 0, 1, 0);
    put    (KIND_LOAD,    0,   0,   0,   7);
    put_chk(KIND_QUERY,  47,   0,   0,   0, 1, 7, 2209, 0, 0);
    put_chk(KIND_QUERY,   0,   0,  48,   0, 0, 0, 2304, 0, 0);
    put    (KIND_QUERY,   0,   0, -48,  99);
    put    (KIND_CLEAR,   0,   0,   0,   0);
    put    (KIND_LOAD, 131071, 131071, 131071, 255);
    put_chk(KIND_QUERY, -131072, -131072, -131072, 0, 0, 0, 206156857347, 0, 0);
    put    (KIND_LOAD, -131072, -131072, -131072, 128);
    put_chk(KIND_QUERY, -131072, -131072, -131071, 3, 1, 128, 1, 0, 0);
    put    (KIND_CLEAR,   0,   0,   0,   0);
    put    (KIND_LOAD,   10,   0,   0,   1);
    put    (KIND_LOAD,  -10,   0,   0,   2);
    put_chk(KIND_QUERY,   0,   0,   0, 255, 1, 1, 100, 0, 0);
    put    (KIND_QUERY,   0,   3,  -4,   0);
    put    (KIND_LOAD, -20000, 65535, -1, 170);
    put    (KIND_QUERY, -20010, 65530, 5,  0);
    put    (KIND_CLEAR,   0,   0,   0,   0);
    put_chk(KIND_QUERY,   5,   5,   5,   0, 0, 0, 0, 1, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    recv_idle_pct = 63;
    foreach (dir_rows[i]) send_hit(dir_rows[i].hit, dir_rows[i].typed, dir_rows[i].want);

    // Random phases, each under its own radius; the last two share an idling mix
    write_radius(32'd1600);
    run_random(38);

    send_idle_pct = 63;
    recv_idle_pct = 35;
    write_radius(32'hFFFF_FFFF);
    run_random(38);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_radius(32'd0);
    hold_req = 1'b1;
    run_random(12);

    write_radius(RADIUS_RESET);
    run_random(24);

    wait_drained();
    repeat (32) @(posedge clk);

    $display("Run: %0d loads, %0d queries, %0d clears, %0d ignored items, %0d radius writes.",
             n_loads, n_queries, n_clears, n_ignored, n_radius);
    $display("Checked %0d results, covering radius edges, extreme coordinates and a long stall.",
             verdicts_checked);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
